FILE: src/hvlc_pkg.sv
// ----------------------------------------------------------------------------
// hvlc_pkg: shared types and helpers of the hex Vigenere line cipher
// Holds the register map, the character codes, the configuration and result
// pair structures, and the key digit and base-32 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hvlc_pkg;

    // Register map: index of each register (byte address is 8 * index)
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;
    localparam logic [1:0] REG_BYPASS   = 2'd3;

    // Character codes
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    // 'a' - 10: offset of the letter digits
    localparam logic [7:0] CH_LET_OFS = 8'd87;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [127:0] key;       // high digits in [127:64], low in [63:0]
        logic         decrypt;
        logic         bypass;
    } cfg_t;

    // Up to two result words caused by one input word
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] char0;
        logic       err0;
        logic [7:0] char1;
        logic       err1;
    } pair_t;

    // Pick key digit at a position (modulo 32)
    function automatic logic [3:0] key_digit(logic [127:0] key, logic [4:0] pos);
        logic [6:0] base;
        base = {pos, 2'b00};
        return key[base +: 4];
    endfunction

    // Base-32 character of a value 0..31
    function automatic logic [7:0] b32_char(logic [4:0] v);
        logic [7:0] ext;
        ext = {3'b000, v};
        return (v < 5'd10) ? (CH_ZERO + ext) : (CH_LET_OFS + ext);
    endfunction

endpackage

`default_nettype wire

FILE: src/hvlc_core.sv
// ----------------------------------------------------------------------------
// hvlc_core: line state and per-character transform
// Holds the digit position, the pending half byte and the line flags, and
// works out the result pair for the word presented at the input.
// ----------------------------------------------------------------------------
`default_nettype none

module hvlc_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire hvlc_pkg::cfg_t cfg,
    input  wire logic [7:0]     char_in,
    input  wire logic           accept,
    output hvlc_pkg::pair_t     pair
);

    logic [4:0] pos_reg,        pos_next;
    logic [3:0] pend_nib_reg,   pend_nib_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_err_reg,   pend_err_next;
    logic       skip_reg,       skip_next;
    logic       lbl_reg,        lbl_next;

    logic [3:0] k0, k1;
    logic [4:0] sum0, sum1;
    logic [9:0] base_val, dig_val;
    logic       dig_err;
    logic [7:0] byte_val;
    logic       line_lf;

    // Key digits for this position and the next
    assign k0 = hvlc_pkg::key_digit(cfg.key, pos_reg);
    assign k1 = hvlc_pkg::key_digit(cfg.key, pos_reg + 5'd1);

    // Encrypt sums of both hex digits
    assign sum0 = {1'b0, char_in[7:4]} + {1'b0, k0};
    assign sum1 = {1'b0, char_in[3:0]} + {1'b0, k1};

    // Decrypt digit: value minus key digit in ten-bit two's complement
    assign base_val = {2'b00, char_in}
                    - {2'b00, (char_in <= hvlc_pkg::CH_NINE) ? hvlc_pkg::CH_ZERO
                                                             : hvlc_pkg::CH_LET_OFS};
    assign dig_val  = base_val - {6'b000000, k0};
    assign dig_err  = (dig_val[9:4] != 6'd0);
    assign byte_val = {pend_nib_reg, dig_val[3:0]};

    // Line end: does the line already close on an LF byte
    assign line_lf = pend_valid_reg ? (pend_nib_reg == hvlc_pkg::CH_LF[3:0])
                                    : lbl_reg;

    // Result pair and next line state
    always_comb begin
        pair            = '0;
        pos_next        = pos_reg;
        pend_nib_next   = pend_nib_reg;
        pend_valid_next = pend_valid_reg;
        pend_err_next   = pend_err_reg;
        skip_next       = skip_reg;
        lbl_next        = lbl_reg;

        if (cfg.bypass) begin
            pair.count = 2'd1;
            pair.char0 = char_in;
        end else if (!cfg.decrypt) begin
            if (char_in == hvlc_pkg::CH_LF) begin
                pair.count = 2'd1;
                pair.char0 = hvlc_pkg::CH_LF;
                pos_next   = 5'd0;
            end else if (char_in != hvlc_pkg::CH_CR) begin
                pair.count = 2'd2;
                pair.char0 = hvlc_pkg::b32_char(sum0);
                pair.char1 = hvlc_pkg::b32_char(sum1);
                pos_next   = pos_reg + 5'd2;
            end
        end else if (skip_reg) begin
            if (char_in == hvlc_pkg::CH_LF) begin
                skip_next = 1'b0;
            end
        end else if (char_in == hvlc_pkg::CH_LF || char_in == hvlc_pkg::CH_CR) begin
            // Flush the odd digit, then close the line
            if (pend_valid_reg) begin
                pair.char0 = {4'b0000, pend_nib_reg};
                pair.err0  = pend_err_reg;
                if (line_lf) begin
                    pair.count = 2'd1;
                end else begin
                    pair.count = 2'd2;
                    pair.char1 = hvlc_pkg::CH_LF;
                end
            end else if (!line_lf) begin
                pair.count = 2'd1;
                pair.char0 = hvlc_pkg::CH_LF;
            end
            pos_next        = 5'd0;
            pend_nib_next   = 4'd0;
            pend_valid_next = 1'b0;
            pend_err_next   = 1'b0;
            lbl_next        = 1'b0;
            skip_next       = (char_in == hvlc_pkg::CH_CR);
        end else begin
            pos_next = pos_reg + 5'd1;
            if (pend_valid_reg) begin
                pair.count      = 2'd1;
                pair.char0      = byte_val;
                pair.err0       = pend_err_reg | dig_err;
                lbl_next        = (byte_val == hvlc_pkg::CH_LF);
                pend_valid_next = 1'b0;
                pend_err_next   = 1'b0;
                pend_nib_next   = 4'd0;
            end else begin
                pend_nib_next   = dig_val[3:0];
                pend_valid_next = 1'b1;
                pend_err_next   = dig_err;
            end
        end
    end

    // Advance line state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 5'd0;
            pend_nib_reg   <= 4'd0;
            pend_valid_reg <= 1'b0;
            pend_err_reg   <= 1'b0;
            skip_reg       <= 1'b0;
            lbl_reg        <= 1'b0;
        end else if (accept) begin
            pos_reg        <= pos_next;
            pend_nib_reg   <= pend_nib_next;
            pend_valid_reg <= pend_valid_next;
            pend_err_reg   <= pend_err_next;
            skip_reg       <= skip_next;
            lbl_reg        <= lbl_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hvlc_obuf.sv
// ----------------------------------------------------------------------------
// hvlc_obuf: result register pair
// Holds up to two result words and hands them out one per cycle while m_ready
// is high; a new pair is loaded as the last held word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module hvlc_obuf (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hvlc_pkg::pair_t pair,
    input  wire logic            load,
    output logic                 load_ok,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_char_out,
    output logic                 m_last,
    output logic                 m_digit_error
);

    logic [1:0] cnt_reg;
    logic [7:0] head_char_reg, tail_char_reg;
    logic       head_err_reg,  tail_err_reg;
    logic       pop;

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_last        = (cnt_reg == 2'd1);
    assign m_char_out    = head_char_reg;
    assign m_digit_error = head_err_reg;
    assign pop           = m_valid & m_ready;

    // Take a new pair once the buffer empties this cycle
    assign load_ok = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    // Count held words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= pair.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Load the pair or shift the tail word forward
    always_ff @(posedge aclk) begin
        if (load) begin
            head_char_reg <= pair.char0;
            head_err_reg  <= pair.err0;
            tail_char_reg <= pair.char1;
            tail_err_reg  <= pair.err1;
        end else if (pop) begin
            head_char_reg <= tail_char_reg;
            head_err_reg  <= tail_err_reg;
        end
    end

endmodule

`default_nettype wire

FILE: src/hex_vigenere_line_cipher_top.sv
// ----------------------------------------------------------------------------
// hex_vigenere_line_cipher_top: hex Vigenere line cipher
// Enciphers or deciphers a character stream line by line with a 32-digit key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_char_in takes one character a word.
//   Result channel m_valid/m_ready/m_char_out/m_last/m_digit_error gives the
//   zero, one or two words each character causes; m_last marks the final one.
//   Program the key, mode and bypass over the APB port while the stream idles.
// Timing and throughput:
//   Results are registered and appear in the cycle after the character is
//   taken. A character giving one result (or none) is taken every cycle
//   while m_ready is high; an enciphered byte gives two cipher digits through
//   the result pair; the next character is taken as the last result leaves.
// Reset:
//   aresetn (synchronous, active low) empties the result register, clears the
//   line state and sets bypass with a zero key in encrypt mode.
// Stall:
//   With m_ready low the held result stays put and s_ready drops once no
//   result slot can be freed.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_vigenere_line_cipher_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Character input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_in,
    // Result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_char_out,
    output logic             m_last,
    output logic             m_digit_error,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [63:0]     key_low_reg, key_high_reg;
    logic            decrypt_reg, bypass_reg;
    logic [1:0]      reg_idx;
    logic            cfg_wr;
    logic            accept;
    hvlc_pkg::cfg_t  cfg;
    hvlc_pkg::pair_t pair;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel & penable & pwrite;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= 64'd0;
            key_high_reg <= 64'd0;
            decrypt_reg  <= 1'b0;
            bypass_reg   <= 1'b1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                hvlc_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                hvlc_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                hvlc_pkg::REG_DECRYPT:  decrypt_reg  <= pwdata[0];
                hvlc_pkg::REG_BYPASS:   bypass_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (reg_idx)
            hvlc_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            hvlc_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            hvlc_pkg::REG_DECRYPT:  prdata = {63'd0, decrypt_reg};
            hvlc_pkg::REG_BYPASS:   prdata = {63'd0, bypass_reg};
            default:                prdata = 64'd0;
        endcase
    end

    assign cfg.key     = {key_high_reg, key_low_reg};
    assign cfg.decrypt = decrypt_reg;
    assign cfg.bypass  = bypass_reg;

    assign accept = s_valid & s_ready;

    hvlc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .char_in (s_char_in),
        .accept  (accept),
        .pair    (pair)
    );

    hvlc_obuf u_obuf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pair          (pair),
        .load          (accept),
        .load_ok       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_out    (m_char_out),
        .m_last        (m_last),
        .m_digit_error (m_digit_error)
    );

endmodule

`default_nettype wire

FILE: src/hvlc_checker.sv
// ----------------------------------------------------------------------------
// hvlc_checker: port-level checks of the line cipher
// Watches the result channel and the input back-pressure over time.
// ----------------------------------------------------------------------------
`default_nettype none

module hvlc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_char_out,
    input wire logic       m_last,
    input wire logic       pready
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_last))
        else $error("stalled result word changed");

    // Follow a non-final word with the rest of its group
    a_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("result group broken off");

    // Drop input ready only while results are held
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !(m_last && m_ready))
        else $error("input stalled with no result held");

    // Keep the configuration port ready
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind hex_vigenere_line_cipher_top hvlc_checker u_hvlc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_char_out (m_char_out),
    .m_last     (m_last),
    .pready     (pready)
);

`default_nettype wire
